FILE: sv/mppt_po_pkg.sv
`timescale 1ns / 1ps

package mppt_po_pkg;

   localparam int CFG_BITS     = 12;
   localparam int STEP_BITS    = 7;
   localparam int CSR_IDX_BITS = 2;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_MAX_VOLTAGE  = 2'd0,
      CSR_MAX_CURRENT  = 2'd1,
      CSR_MIN_CURRENT  = 2'd2,
      CSR_OV_STEPS     = 2'd3
   } csr_index_type;

   localparam logic [CFG_BITS-1:0]  MAX_VOLTAGE_RESET = 12'd3716;
   localparam logic [CFG_BITS-1:0]  MAX_CURRENT_RESET = 12'd1365;
   localparam logic [CFG_BITS-1:0]  MIN_CURRENT_RESET = 12'd137;
   localparam logic [STEP_BITS-1:0] OV_STEPS_RESET    = 7'd92;

   typedef struct packed {
      logic [CFG_BITS-1:0]  max_voltage_code;
      logic [CFG_BITS-1:0]  max_current_code;
      logic [CFG_BITS-1:0]  min_current_code;
      logic [STEP_BITS-1:0] overvoltage_wiper_steps;
   } cfg_type;

   typedef struct packed {
      logic                 two_cmds;
      logic                 move_up;
      logic [STEP_BITS-1:0] preset_steps;
   } decision_type;

endpackage

FILE: sv/mppt_po_ifs.sv
`timescale 1ns / 1ps

interface mppt_po_req_if #(parameter int ADC_BITS = 12);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] current_code;
   logic [ADC_BITS-1:0] voltage_code;

   modport source (output valid, current_code, voltage_code, input ready);
   modport sink   (input valid, current_code, voltage_code, output ready);
endinterface

interface mppt_po_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [mppt_po_pkg::STEP_BITS-1:0]  wiper_steps;
   logic                               move_up;
   logic                               last_command;

   modport source (output valid, wiper_steps, move_up, last_command, input ready);
   modport sink   (input valid, wiper_steps, move_up, last_command, output ready);
endinterface

interface mppt_po_csr_if;
   logic                                 valid;
   logic                                 ready;
   logic [mppt_po_pkg::CSR_IDX_BITS-1:0] index;
   logic [mppt_po_pkg::CFG_BITS-1:0]     data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/mppt_perturb_observe_core.sv
`timescale 1ns / 1ps
// Channel   Role    Fields
// req_bus   sink    current_code, voltage_code
// rsp_bus   source  wiper_steps, move_up, last_command
// csr_bus   sink    index, data (always ready)
//
// A sample waits in the input register until the output register can load it;
// its first command is then registered there. Normal samples sustain one per
// cycle while the response is ready; an over-voltage sample holds the output
// register for two transfers. Reset restores default thresholds and clears
// the stored power and the direction. A stalled response holds both stages;
// the input register refills as the output register's final command transfers.

module mppt_perturb_observe_core #(
   parameter int ADC_BITS         = 12,
   parameter int WIPER_FULL_STEPS = 100
) (
   input  logic           clock,
   input  logic           reset,
   mppt_po_req_if.sink    req_bus,
   mppt_po_rsp_if.source  rsp_bus,
   mppt_po_csr_if.sink    csr_bus
);

   mppt_po_pkg::cfg_type      cfg;
   mppt_po_pkg::decision_type dec;
   logic                      dec_valid;
   logic                      load_ok;

   mppt_po_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .csr_bus (csr_bus),
      .cfg     (cfg)
   );

   mppt_po_eval #(
      .ADC_BITS         (ADC_BITS),
      .WIPER_FULL_STEPS (WIPER_FULL_STEPS)
   ) u_eval (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .cfg       (cfg),
      .load_ok   (load_ok),
      .dec_valid (dec_valid),
      .dec       (dec)
   );

   mppt_po_out #(
      .WIPER_FULL_STEPS (WIPER_FULL_STEPS)
   ) u_out (
      .clock     (clock),
      .reset     (reset),
      .dec_valid (dec_valid),
      .dec       (dec),
      .load_ok   (load_ok),
      .rsp_bus   (rsp_bus)
   );

endmodule

FILE: sv/mppt_po_csr.sv
`timescale 1ns / 1ps

module mppt_po_csr (
   input  logic                 clock,
   input  logic                 reset,
   mppt_po_csr_if.sink          csr_bus,
   output mppt_po_pkg::cfg_type cfg
);

   mppt_po_pkg::cfg_type cfg_ff;
   mppt_po_pkg::cfg_type cfg_in;

   assign csr_bus.ready = 1'b1;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_bus.valid) begin
         case (mppt_po_pkg::csr_index_type'(csr_bus.index))
            mppt_po_pkg::CSR_MAX_VOLTAGE: cfg_in.max_voltage_code = csr_bus.data;
            mppt_po_pkg::CSR_MAX_CURRENT: cfg_in.max_current_code = csr_bus.data;
            mppt_po_pkg::CSR_MIN_CURRENT: cfg_in.min_current_code = csr_bus.data;
            mppt_po_pkg::CSR_OV_STEPS:
               cfg_in.overvoltage_wiper_steps = csr_bus.data[mppt_po_pkg::STEP_BITS-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_voltage_code        <= mppt_po_pkg::MAX_VOLTAGE_RESET;
         cfg_ff.max_current_code        <= mppt_po_pkg::MAX_CURRENT_RESET;
         cfg_ff.min_current_code        <= mppt_po_pkg::MIN_CURRENT_RESET;
         cfg_ff.overvoltage_wiper_steps <= mppt_po_pkg::OV_STEPS_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: sv/mppt_po_eval.sv
`timescale 1ns / 1ps

module mppt_po_eval #(
   parameter int ADC_BITS         = 12,
   parameter int WIPER_FULL_STEPS = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   mppt_po_req_if.sink               req_bus,
   input  mppt_po_pkg::cfg_type      cfg,
   input  logic                      load_ok,
   output logic                      dec_valid,
   output mppt_po_pkg::decision_type dec
);

   localparam int POW_BITS = 2 * ADC_BITS;
   localparam int CMP_BITS = (ADC_BITS > mppt_po_pkg::CFG_BITS) ?
                             ADC_BITS : mppt_po_pkg::CFG_BITS;
   localparam logic [mppt_po_pkg::STEP_BITS-1:0] FULL_STEPS =
      mppt_po_pkg::STEP_BITS'(WIPER_FULL_STEPS);

   logic                s1_valid_ff, s1_valid_in;
   logic [ADC_BITS-1:0] cur_ff, volt_ff;
   logic [POW_BITS-1:0] prev_power_ff, prev_power_in;
   logic                dir_up_ff, dir_up_in;

   logic                accept, advance;
   logic [POW_BITS-1:0] power;
   logic [CMP_BITS-1:0] cur_ext, volt_ext;
   logic                over_voltage, low_current, high_current, track;
   logic                new_dir;

   assign req_bus.ready = !s1_valid_ff || load_ok;
   assign accept  = req_bus.valid && req_bus.ready;
   assign advance = s1_valid_ff && load_ok;

   assign power    = POW_BITS'(cur_ff) * POW_BITS'(volt_ff);
   assign cur_ext  = CMP_BITS'(cur_ff);
   assign volt_ext = CMP_BITS'(volt_ff);

   assign over_voltage = volt_ext > CMP_BITS'(cfg.max_voltage_code);
   assign low_current  = cur_ext < CMP_BITS'(cfg.min_current_code);
   assign high_current = cur_ext > CMP_BITS'(cfg.max_current_code);
   assign track        = !over_voltage && !low_current && !high_current;
   assign new_dir      = (power > prev_power_ff) ? dir_up_ff : !dir_up_ff;

   always_comb begin
      dec_valid        = s1_valid_ff;
      dec.two_cmds     = over_voltage;
      dec.preset_steps = (cfg.overvoltage_wiper_steps > FULL_STEPS) ?
                         FULL_STEPS : cfg.overvoltage_wiper_steps;
      if (low_current) begin
         dec.move_up = 1'b0;
      end else if (high_current) begin
         dec.move_up = 1'b1;
      end else begin
         dec.move_up = new_dir;
      end
   end

   always_comb begin
      s1_valid_in   = s1_valid_ff;
      prev_power_in = prev_power_ff;
      dir_up_in     = dir_up_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (advance) begin
         s1_valid_in = 1'b0;
      end
      if (advance && track) begin
         prev_power_in = power;
         dir_up_in     = new_dir;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff   <= 1'b0;
         prev_power_ff <= '0;
         dir_up_ff     <= 1'b0;
      end else begin
         s1_valid_ff   <= s1_valid_in;
         prev_power_ff <= prev_power_in;
         dir_up_ff     <= dir_up_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         cur_ff  <= req_bus.current_code;
         volt_ff <= req_bus.voltage_code;
      end
   end

endmodule

FILE: sv/mppt_po_out.sv
`timescale 1ns / 1ps

module mppt_po_out #(
   parameter int WIPER_FULL_STEPS = 100
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      dec_valid,
   input  mppt_po_pkg::decision_type dec,
   output logic                      load_ok,
   mppt_po_rsp_if.source             rsp_bus
);

   localparam logic [mppt_po_pkg::STEP_BITS-1:0] FULL_STEPS =
      mppt_po_pkg::STEP_BITS'(WIPER_FULL_STEPS);

   logic                              out_valid_ff, out_valid_in;
   logic                              phase_ff, phase_in;
   logic                              two_ff;
   logic                              up_ff;
   logic [mppt_po_pkg::STEP_BITS-1:0] steps_ff;
   logic                              xfer, last_xfer, load;

   assign xfer      = out_valid_ff && rsp_bus.ready;
   assign last_xfer = xfer && (!two_ff || phase_ff);
   assign load_ok   = !out_valid_ff || last_xfer;
   assign load      = dec_valid && load_ok;

   assign rsp_bus.valid        = out_valid_ff;
   assign rsp_bus.wiper_steps  = two_ff ? (phase_ff ? steps_ff : FULL_STEPS) : '0;
   assign rsp_bus.move_up      = two_ff ? !phase_ff : up_ff;
   assign rsp_bus.last_command = !two_ff || phase_ff;

   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      if (load) begin
         out_valid_in = 1'b1;
         phase_in     = 1'b0;
      end else if (last_xfer) begin
         out_valid_in = 1'b0;
         phase_in     = 1'b0;
      end else if (xfer) begin
         phase_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         two_ff   <= dec.two_cmds;
         up_ff    <= dec.move_up;
         steps_ff <= dec.preset_steps;
      end
   end

endmodule

FILE: sv/mppt_po_checker.sv
`timescale 1ns / 1ps

module mppt_po_checker #(
   parameter int WIPER_FULL_STEPS = 100
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [mppt_po_pkg::STEP_BITS-1:0] rsp_wiper_steps,
   input logic                              rsp_move_up,
   input logic                              rsp_last_command
);

   localparam logic [mppt_po_pkg::STEP_BITS-1:0] FULL_STEPS =
      mppt_po_pkg::STEP_BITS'(WIPER_FULL_STEPS);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_last_command |=>
         rsp_valid && rsp_last_command && !rsp_move_up)
      else $error("preset command did not follow full-scale command");

   a_full_scale_first: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_command |-> rsp_move_up && rsp_wiper_steps == FULL_STEPS)
      else $error("non-final command is not a full-scale upward move");

   a_single_up_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last_command && rsp_move_up |-> rsp_wiper_steps == '0)
      else $error("single upward command carries steps");

endmodule

bind mppt_perturb_observe_core mppt_po_checker #(
   .WIPER_FULL_STEPS (WIPER_FULL_STEPS)
) u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_wiper_steps  (rsp_bus.wiper_steps),
   .rsp_move_up      (rsp_bus.move_up),
   .rsp_last_command (rsp_bus.last_command)
);
